// ----- design/trpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch report press tracker package
// Shared widths, register indexes, event codes and reset values.
// ----------------------------------------------------------------------------
package trpt_pkg;

    // Configuration port geometry: three 32-bit registers at 0x0, 0x4 and 0x8.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MISS_LIMIT   = 2'd2;

    // Field widths.
    localparam int SIZE_W  = 13;
    localparam int COORD_W = 12;
    localparam int COUNT_W = 4;
    localparam int KIND_W  = 2;

    // Largest panel size that still maps into 12-bit coordinates.
    localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

    // Register reset values.
    localparam logic [SIZE_W-1:0]  PANEL_WIDTH_RST  = 13'd172;
    localparam logic [SIZE_W-1:0]  PANEL_HEIGHT_RST = 13'd320;
    localparam logic [COUNT_W-1:0] MISS_LIMIT_RST   = 4'd3;

    // Event codes.
    localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

endpackage

// ----- design/trpt_ifs.sv -----
// ----------------------------------------------------------------------------
// Touch report press tracker channel interfaces
// Valid/ready channels for poll results in and pointer events out.
// ----------------------------------------------------------------------------
interface trpt_poll_if;
    logic       valid;
    logic       ready;
    logic       read_ok;
    logic [7:0] status_byte;
    logic [7:0] x_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] y_low_byte;

    modport source (
        output valid, read_ok, status_byte, x_high_byte, x_low_byte,
               y_high_byte, y_low_byte,
        input  ready
    );
    modport sink (
        input  valid, read_ok, status_byte, x_high_byte, x_low_byte,
               y_high_byte, y_low_byte,
        output ready
    );
endinterface

interface trpt_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [11:0] event_x;
    logic [11:0] event_y;

    modport source (
        output valid, event_kind, event_x, event_y,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_x, event_y,
        output ready
    );
endinterface

// ----- design/touch_report_press_tracker_top.sv -----
// A poll result is taken into the input register on its transfer; its event, if
// any, is loaded into the result register when the held poll moves on. One poll
// per cycle while events are taken. While an event waits on the output, one more
// poll is taken into the input register, then the input stalls until the transfer.
// Reset (i_rst_n low, synchronous): both registers empty, touch state cleared,
// configuration back to width 172, height 320, miss limit 3.
// ----------------------------------------------------------------------------
// Touch report press tracker
// Turns touch-controller poll results into pointer down, move and up events,
// with coordinate clamping, x mirroring and a debounced release.
// ----------------------------------------------------------------------------
module touch_report_press_tracker_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    trpt_poll_if.sink                   i_poll,
    trpt_event_if.source                o_event,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [trpt_pkg::PADDR_W-1:0] i_paddr,
    input  logic [trpt_pkg::PDATA_W-1:0] i_pwdata,
    output logic [trpt_pkg::PDATA_W-1:0] o_prdata,
    output logic                        o_pready
);
    import trpt_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The port never waits, so a write lands at
    // the edge of its access cycle. Addresses past the last register are
    // accepted and ignored.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  r_panel_width;
    logic [SIZE_W-1:0]  r_panel_height;
    logic [COUNT_W-1:0] r_miss_limit;
    logic               cfg_write;

    assign o_pready  = 1'b1;
    assign cfg_write = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_width  <= PANEL_WIDTH_RST;
            r_panel_height <= PANEL_HEIGHT_RST;
            r_miss_limit   <= MISS_LIMIT_RST;
        end else if (cfg_write) begin
            unique case (i_paddr[3:2])
                REG_PANEL_WIDTH:  r_panel_width  <= i_pwdata[SIZE_W-1:0];
                REG_PANEL_HEIGHT: r_panel_height <= i_pwdata[SIZE_W-1:0];
                REG_MISS_LIMIT:   r_miss_limit   <= i_pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            REG_PANEL_WIDTH:  o_prdata = PDATA_W'(r_panel_width);
            REG_PANEL_HEIGHT: o_prdata = PDATA_W'(r_panel_height);
            REG_MISS_LIMIT:   o_prdata = PDATA_W'(r_miss_limit);
            default:          o_prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register. Only the bits that matter are kept: the read status
    // bit, the point count nibble and the two raw 12-bit coordinates.
    // ------------------------------------------------------------------
    logic               r_in_valid;
    logic               r_in_ok;
    logic [3:0]         r_in_count;
    logic [COORD_W-1:0] r_in_raw_x;
    logic [COORD_W-1:0] r_in_raw_y;
    logic               advance;
    logic               in_xfer;

    // The held poll moves on once the result register is free or drains in
    // this same cycle. A new poll is taken whenever the input register is
    // empty or moves on.
    assign advance      = r_in_valid && (!o_event.valid || o_event.ready);
    assign i_poll.ready = !r_in_valid || advance;
    assign in_xfer      = i_poll.valid && i_poll.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_poll.ready) begin
            r_in_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_ok    <= i_poll.read_ok;
            r_in_count <= i_poll.status_byte[3:0];
            r_in_raw_x <= {i_poll.x_high_byte[3:0], i_poll.x_low_byte};
            r_in_raw_y <= {i_poll.y_high_byte[3:0], i_poll.y_low_byte};
        end
    end

    // ------------------------------------------------------------------
    // Coordinate mapping. A zero panel size behaves as one pixel and sizes
    // above 4096 behave as 4096, so the largest pixel index always fits in
    // 12 bits. X is clamped then mirrored; y is only clamped.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  eff_w;
    logic [SIZE_W-1:0]  eff_h;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] clamp_x;
    logic [COORD_W-1:0] map_x;
    logic [COORD_W-1:0] map_y;

    always_comb begin
        if (r_panel_width == '0) begin
            eff_w = SIZE_W'(1);
        end else if (r_panel_width > SIZE_MAX) begin
            eff_w = SIZE_MAX;
        end else begin
            eff_w = r_panel_width;
        end
        if (r_panel_height == '0) begin
            eff_h = SIZE_W'(1);
        end else if (r_panel_height > SIZE_MAX) begin
            eff_h = SIZE_MAX;
        end else begin
            eff_h = r_panel_height;
        end
    end

    assign max_x   = COORD_W'(eff_w - SIZE_W'(1));
    assign max_y   = COORD_W'(eff_h - SIZE_W'(1));
    assign clamp_x = (r_in_raw_x > max_x) ? max_x : r_in_raw_x;
    assign map_x   = max_x - clamp_x;
    assign map_y   = (r_in_raw_y > max_y) ? max_y : r_in_raw_y;

    // ------------------------------------------------------------------
    // Touch state and event decision. A poll with points gives a down
    // event from the released state (recording the start position) or a
    // move event while held, and clears the miss count. While held, an
    // empty poll counts a miss; when the count reaches the limit an up
    // event is sent at the start position. Failed reads and empty polls
    // while released leave everything unchanged.
    // ------------------------------------------------------------------
    logic               r_pressed;
    logic [COUNT_W-1:0] r_miss_count;
    logic [COORD_W-1:0] r_start_x;
    logic [COORD_W-1:0] r_start_y;

    logic               n_pressed;
    logic [COUNT_W-1:0] n_miss_count;
    logic               n_has_event;
    logic [KIND_W-1:0]  n_kind;
    logic [COORD_W-1:0] n_x;
    logic [COORD_W-1:0] n_y;
    logic               take_start;
    logic [COUNT_W:0]   miss_inc;

    assign miss_inc = {1'b0, r_miss_count} + (COUNT_W+1)'(1);

    always_comb begin
        n_pressed    = r_pressed;
        n_miss_count = r_miss_count;
        n_has_event  = 1'b0;
        n_kind       = KIND_MOVE;
        n_x          = map_x;
        n_y          = map_y;
        take_start   = 1'b0;
        if (r_in_ok) begin
            if (r_in_count != 4'd0) begin
                n_pressed    = 1'b1;
                n_miss_count = '0;
                n_has_event  = 1'b1;
                n_kind       = r_pressed ? KIND_MOVE : KIND_DOWN;
                take_start   = !r_pressed;
            end else if (r_pressed) begin
                if (miss_inc < {1'b0, r_miss_limit}) begin
                    n_miss_count = miss_inc[COUNT_W-1:0];
                end else begin
                    n_pressed    = 1'b0;
                    n_miss_count = '0;
                    n_has_event  = 1'b1;
                    n_kind       = KIND_UP;
                    n_x          = r_start_x;
                    n_y          = r_start_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed    <= 1'b0;
            r_miss_count <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
        end else if (advance) begin
            r_pressed    <= n_pressed;
            r_miss_count <= n_miss_count;
            if (take_start) begin
                r_start_x <= map_x;
                r_start_y <= map_y;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register. It loads when the held poll moves on, and empties
    // once its event has been transferred.
    // ------------------------------------------------------------------
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_has_event;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_has_event) begin
            r_out_kind <= n_kind;
            r_out_x    <= n_x;
            r_out_y    <= n_y;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_kind = r_out_kind;
    assign o_event.event_x    = r_out_x;
    assign o_event.event_y    = r_out_y;

endmodule

// ----- design/trpt_checker.sv -----
// ----------------------------------------------------------------------------
// Touch report press tracker checker
// Port-level assertions on the event channel and the configuration port.
// ----------------------------------------------------------------------------
module trpt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_ev_valid,
    input logic                         i_ev_ready,
    input logic [1:0]                   i_ev_kind,
    input logic [11:0]                  i_ev_x,
    input logic [11:0]                  i_ev_y,
    input logic                         i_psel,
    input logic                         i_penable,
    input logic                         i_pwrite,
    input logic [trpt_pkg::PADDR_W-1:0] i_paddr,
    input logic [trpt_pkg::PDATA_W-1:0] i_pwdata,
    input logic [trpt_pkg::PDATA_W-1:0] i_prdata,
    input logic                         i_pready
);
    import trpt_pkg::*;

    // A stalled event keeps its contents.
    a_event_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid && !i_ev_ready |=>
            i_ev_valid && $stable(i_ev_kind) && $stable(i_ev_x) && $stable(i_ev_y))
        else $error("event changed while stalled");

    // Only down, move and up codes are ever sent.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid |-> (i_ev_kind == KIND_DOWN || i_ev_kind == KIND_MOVE ||
                        i_ev_kind == KIND_UP))
        else $error("invalid event code");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_ev_valid)
        else $error("event valid right after reset");

    // A width write reads back on the following cycle.
    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_pready &&
         i_paddr[3:2] == REG_PANEL_WIDTH) ##1
        (i_psel && !i_pwrite && i_paddr[3:2] == REG_PANEL_WIDTH && $past(i_rst_n)) |->
            i_prdata == PDATA_W'($past(i_pwdata[SIZE_W-1:0]))
        )
        else $error("panel width readback mismatch");

endmodule

bind touch_report_press_tracker_top trpt_checker u_trpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_ev_valid (o_event.valid),
    .i_ev_ready (o_event.ready),
    .i_ev_kind  (o_event.event_kind),
    .i_ev_x     (o_event.event_x),
    .i_ev_y     (o_event.event_y),
    .i_psel     (i_psel),
    .i_penable  (i_penable),
    .i_pwrite   (i_pwrite),
    .i_paddr    (i_paddr),
    .i_pwdata   (i_pwdata),
    .i_prdata   (o_prdata),
    .i_pready   (o_pready)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch report press tracker testbench
// Plays a short scripted sequence of controller polls and register writes,
// then random touch gestures under several panel and release settings, and
// checks every pointer event against a bench tracker or a scripted result.
// ----------------------------------------------------------------------------
module tb;
    import trpt_pkg::*;

    // The run is cut off after this many clock cycles.
    localparam int CYCLE_LIMIT = 100000;

    // At least 320 counted polls in all, spread over the random phases; each phase
    // counts only the polls that the tracker acts on.
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 40;

    // The random stimulus idles in about this many cycles out of a hundred.
    localparam int IDLE_PCT = 38;

    typedef struct packed {
        logic       read_ok;
        logic [7:0] status_byte;
        logic [7:0] x_high_byte;
        logic [7:0] x_low_byte;
        logic [7:0] y_high_byte;
        logic [7:0] y_low_byte;
    } poll_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } touch_event_t;

    // How a scripted poll is checked: against the tracker, against a result
    // typed into the script, or with no event allowed at all.
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_EVENT} check_e;
    typedef enum logic {STEP_POLL, STEP_WRITE} step_e;
    typedef enum logic [1:0] {SHAPE_POINT, SHAPE_EMPTY, SHAPE_FAILED, SHAPE_ANY} shape_e;

    typedef struct {
        step_e        step;
        check_e       chk;
        poll_t        poll;
        touch_event_t ev;
        logic [1:0]   reg_idx;
        logic [12:0]  value;
    } script_row_t;

    localparam touch_event_t NO_EVENT = '0;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_psel;
    logic                i_penable;
    logic                i_pwrite;
    logic [PADDR_W-1:0]  i_paddr;
    logic [PDATA_W-1:0]  i_pwdata;
    logic [PDATA_W-1:0]  o_prdata;
    logic                o_pready;

    trpt_poll_if  poll_ch ();
    trpt_event_if evt_ch ();

    touch_report_press_tracker_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_poll    (poll_ch),
        .o_event   (evt_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bench copy of the configuration, updated on every register write.
    logic [SIZE_W-1:0]  cfg_width  = PANEL_WIDTH_RST;
    logic [SIZE_W-1:0]  cfg_height = PANEL_HEIGHT_RST;
    logic [COUNT_W-1:0] cfg_limit  = MISS_LIMIT_RST;

    // Bench copy of the touch state.
    logic               touch_held = 1'b0;
    int                 miss_run   = 0;
    logic [COORD_W-1:0] anchor_x   = '0;
    logic [COORD_W-1:0] anchor_y   = '0;

    // Pointer events that the block still owes, oldest first.
    touch_event_t pending_events [$];

    int event_mismatches = 0;
    int cycles           = 0;

    // When set, neither side idles. One whole random phase runs this way.
    bit steady = 1'b0;

    // A panel size of zero acts as one pixel, and anything above 4096 acts
    // as 4096, so coordinates always fit in 12 bits.
    function automatic int fit_size(input logic [SIZE_W-1:0] size);
        if (size == 0) return 1;
        if (size > SIZE_MAX) return int'(SIZE_MAX);
        return int'(size);
    endfunction

    // Advances the bench touch state by one accepted poll and returns 1 when
    // the poll produces a pointer event, which is then placed in ev.
    function automatic bit track_poll(input poll_t p, output touch_event_t ev);
        int w;
        int h;
        int raw_x;
        int raw_y;
        int cx;
        int cy;
        int next_miss;
        ev = NO_EVENT;
        // A failed bus read is dropped without touching any state.
        if (!p.read_ok) return 1'b0;
        if (p.status_byte[3:0] != 4'd0) begin
            w     = fit_size(cfg_width);
            h     = fit_size(cfg_height);
            raw_x = int'({p.x_high_byte[3:0], p.x_low_byte});
            raw_y = int'({p.y_high_byte[3:0], p.y_low_byte});
            cx    = (raw_x > w - 1) ? w - 1 : raw_x;
            cy    = (raw_y > h - 1) ? h - 1 : raw_y;
            ev.kind = touch_held ? KIND_MOVE : KIND_DOWN;
            // X is mirrored across the panel after clamping.
            ev.x    = 12'(w - 1 - cx);
            ev.y    = 12'(cy);
            if (!touch_held) begin
                anchor_x = ev.x;
                anchor_y = ev.y;
            end
            touch_held = 1'b1;
            miss_run   = 0;
            return 1'b1;
        end
        // An empty poll only matters while a touch is held.
        if (!touch_held) return 1'b0;
        next_miss = miss_run + 1;
        if (next_miss < int'(cfg_limit)) begin
            miss_run = next_miss;
            return 1'b0;
        end
        // Release: the up event reports where the touch started.
        touch_held = 1'b0;
        miss_run   = 0;
        ev         = {KIND_UP, anchor_x, anchor_y};
        return 1'b1;
    endfunction

    function automatic script_row_t poll_step(input poll_t p, input check_e chk,
                                              input touch_event_t ev);
        script_row_t r;
        r.step    = STEP_POLL;
        r.chk     = chk;
        r.poll    = p;
        r.ev      = ev;
        r.reg_idx = '0;
        r.value   = '0;
        return r;
    endfunction

    function automatic script_row_t write_step(input logic [1:0] idx,
                                               input logic [12:0] value);
        script_row_t r;
        r.step    = STEP_WRITE;
        r.chk     = CHK_NONE;
        r.poll    = '0;
        r.ev      = NO_EVENT;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    function automatic poll_t make_poll(input shape_e shape);
        poll_t p;
        p.read_ok     = (shape == SHAPE_ANY) ? 1'($urandom_range(1)) : (shape != SHAPE_FAILED);
        p.status_byte = 8'($urandom_range(255));
        p.x_high_byte = 8'($urandom_range(255));
        p.x_low_byte  = 8'($urandom_range(255));
        p.y_high_byte = 8'($urandom_range(255));
        p.y_low_byte  = 8'($urandom_range(255));
        case (shape)
            SHAPE_POINT: p.status_byte[3:0] = 4'($urandom_range(1, 15));
            SHAPE_EMPTY: p.status_byte[3:0] = 4'd0;
            default: ;
        endcase
        return p;
    endfunction

    // Mostly ordinary panel sizes, with the degenerate and oversized ones mixed in.
    function automatic logic [12:0] pick_size();
        case ($urandom_range(7))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'($urandom_range(2, 16));
            3:       return 13'($urandom_range(17, 400));
            4:       return SIZE_MAX;
            5:       return 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(100, 4095));
        endcase
    endfunction

    function automatic void note_mismatch(input string what);
        if (event_mismatches < 10) $display("mismatch at %0t ns: %s", $time, what);
        event_mismatches++;
    endfunction

    // Two-phase register write. The register takes the value at the access
    // edge; the bench copy follows right after.
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        logic done;
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= {19'd0, value};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = o_pready;
            @(posedge i_clk);
        end while (!done);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        case (idx)
            REG_PANEL_WIDTH:  cfg_width  = value;
            REG_PANEL_HEIGHT: cfg_height = value;
            REG_MISS_LIMIT:   cfg_limit  = value[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Lets the block go idle: no poll offered, every owed event delivered,
    // and a further wait for a poll that produced no event to leave the
    // pipeline.
    task automatic settle();
        poll_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offers one poll, waits for its transfer, then records what it should
    // produce. The ready line is sampled at the falling edge, where it has
    // settled, and the transfer takes place at the rising edge that follows.
    task automatic send_poll(input poll_t p, input check_e chk, input touch_event_t typed);
        touch_event_t ev;
        bit           has_ev;
        logic         took;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            poll_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        poll_ch.valid       <= 1'b1;
        poll_ch.read_ok     <= p.read_ok;
        poll_ch.status_byte <= p.status_byte;
        poll_ch.x_high_byte <= p.x_high_byte;
        poll_ch.x_low_byte  <= p.x_low_byte;
        poll_ch.y_high_byte <= p.y_high_byte;
        poll_ch.y_low_byte  <= p.y_low_byte;
        do begin
            @(negedge i_clk);
            took = poll_ch.ready;
            @(posedge i_clk);
        end while (took !== 1'b1);
        has_ev = track_poll(p, ev);
        case (chk)
            CHK_MODEL: if (has_ev) pending_events.push_back(ev);
            CHK_EVENT: pending_events.push_back(typed);
            default: ;
        endcase
    endtask

    // Sends one random poll of the given shape and tells whether the tracker
    // acts on it; failed reads and empty polls with no touch held do not count.
    task automatic send_random(input shape_e shape, inout int live_items);
        poll_t p;
        p = make_poll(shape);
        if (p.read_ok && (p.status_byte[3:0] != 4'd0 || touch_held)) live_items++;
        send_poll(p, CHK_MODEL, NO_EVENT);
    endtask

    // Event side: ready is redrawn every cycle, and an event is checked at
    // the falling edge before the rising edge that completes its transfer.
    initial begin
        touch_event_t got;
        touch_event_t want;
        evt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            evt_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            @(negedge i_clk);
            if (i_rst_n === 1'b1 && evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) begin
                got = {evt_ch.event_kind, evt_ch.event_x, evt_ch.event_y};
                if (pending_events.size() == 0) begin
                    note_mismatch($sformatf("event with none expected: kind %0d x %0d y %0d",
                                            got.kind, got.x, got.y));
                end else begin
                    want = pending_events.pop_front();
                    if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y)
                        note_mismatch($sformatf("expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
                                                want.kind, want.x, want.y,
                                                got.kind, got.x, got.y));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        script_row_t script [$];
        int          live_items;
        int          ph;
        int          r;
        int          n;

        // Scripted part, starting from the reset settings: width 172,
        // height 320, release after three empty polls.
        script = '{
            // First touch at the origin: x mirrors to 171. The high nibbles
            // of the status and high bytes are set and must be ignored.
            poll_step({1'b1, 8'hF1, 8'hF0, 8'h00, 8'hF0, 8'h00}, CHK_EVENT,
                      {KIND_DOWN, 12'd171, 12'd0}),
            poll_step({1'b1, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_EVENT),
            // A failed read is ignored even with points and all coordinate bytes set.
            poll_step({1'b0, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, CHK_NONE, NO_EVENT),
            // Largest raw coordinates clamp to the panel edge; this poll
            // also clears the miss counted above.
            poll_step({1'b1, 8'h0F, 8'h0F, 8'hFF, 8'h0F, 8'hFF}, CHK_EVENT,
                      {KIND_MOVE, 12'd0, 12'd319}),
            poll_step({1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, CHK_NONE, NO_EVENT),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_EVENT),
            // Third empty poll releases at the start position.
            poll_step({1'b1, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_EVENT,
                      {KIND_UP, 12'd171, 12'd0}),
            // An empty poll with no touch held gives nothing.
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_EVENT),
            // Zero width acts as one pixel, an oversized height as 4096, and
            // a zero miss limit releases on the first empty poll.
            write_step(REG_PANEL_WIDTH, 13'd0),
            write_step(REG_PANEL_HEIGHT, 13'h1FFF),
            write_step(REG_MISS_LIMIT, 13'd0),
            poll_step({1'b1, 8'h02, 8'hF5, 8'hA5, 8'h3A, 8'h5A}, CHK_EVENT,
                      {KIND_DOWN, 12'd0, 12'hA5A}),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_EVENT,
                      {KIND_UP, 12'd0, 12'hA5A}),
            // Full 4096 panel and the largest miss limit.
            write_step(REG_PANEL_WIDTH, 13'd4096),
            write_step(REG_PANEL_HEIGHT, 13'd4096),
            write_step(REG_MISS_LIMIT, 13'd15),
            poll_step({1'b1, 8'h01, 8'h00, 8'h00, 8'h0F, 8'hFF}, CHK_EVENT,
                      {KIND_DOWN, 12'd4095, 12'd4095}),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_EVENT),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_EVENT),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_EVENT),
            // Three misses are counted; lowering the limit to two means the
            // next empty poll releases.
            write_step(REG_MISS_LIMIT, 13'd2),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_EVENT,
                      {KIND_UP, 12'd4095, 12'd4095}),
            // Width just past 4096 and a one-pixel height.
            write_step(REG_PANEL_WIDTH, 13'd4097),
            write_step(REG_PANEL_HEIGHT, 13'd1),
            poll_step({1'b1, 8'h03, 8'h01, 8'h23, 8'h04, 8'h56}, CHK_MODEL, NO_EVENT),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_EVENT),
            poll_step({1'b1, 8'h05, 8'h08, 8'h80, 8'h00, 8'h00}, CHK_MODEL, NO_EVENT),
            poll_step({1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_EVENT),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_EVENT),
            poll_step({1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_EVENT)
        };

        // Every input is known from time zero, and reset is held low at the start.
        i_rst_n             <= 1'b0;
        i_psel              <= 1'b0;
        i_penable           <= 1'b0;
        i_pwrite            <= 1'b0;
        i_paddr             <= '0;
        i_pwdata            <= '0;
        poll_ch.valid       <= 1'b0;
        poll_ch.read_ok     <= 1'b0;
        poll_ch.status_byte <= '0;
        poll_ch.x_high_byte <= '0;
        poll_ch.x_low_byte  <= '0;
        poll_ch.y_high_byte <= '0;
        poll_ch.y_low_byte  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].step == STEP_WRITE) begin
                settle();
                write_reg(script[i].reg_idx, script[i].value);
            end else begin
                send_poll(script[i].poll, script[i].chk, script[i].ev);
            end
        end

        // Random part: each phase draws new panel sizes and a new miss limit,
        // then plays touch gestures. A gesture is a run of polls with points,
        // with a few empty polls and failed reads mixed in, followed by a run
        // of empty polls, up to two more than the miss limit, that may release. About
        // one gesture in ten is plain noise.
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            write_reg(REG_PANEL_WIDTH, pick_size());
            write_reg(REG_PANEL_HEIGHT, pick_size());
            write_reg(REG_MISS_LIMIT, 13'($urandom_range(15)));
            // The third phase runs with both sides always ready.
            steady     = (ph == 2);
            live_items = 0;
            while (live_items < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_random(SHAPE_ANY, live_items);
                end else begin
                    n = $urandom_range(1, 10);
                    repeat (n) begin
                        r = $urandom_range(99);
                        if (r < 8)       send_random(SHAPE_FAILED, live_items);
                        else if (r < 20) send_random(SHAPE_EMPTY, live_items);
                        else             send_random(SHAPE_POINT, live_items);
                    end
                    n = $urandom_range(0, int'(cfg_limit) + 2);
                    repeat (n) begin
                        if ($urandom_range(99) < 8) send_random(SHAPE_FAILED, live_items);
                        else                        send_random(SHAPE_EMPTY, live_items);
                    end
                end
            end
        end
        steady = 1'b0;

        // Drain: wait for every owed event, then go on waiting so that a stray
        // extra event would still be caught.
        poll_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (event_mismatches == 0 && pending_events.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
